// ===== hw/rtl/hadm_pkg.sv =====
`timescale 1ns / 1ps

package hadm_pkg;

    // mode codes, numbered densely from startup
    localparam logic [3:0] MODE_STARTUP = 4'd0;
    localparam logic [3:0] MODE_NSETUP  = 4'd1;
    localparam logic [3:0] MODE_NWAIT   = 4'd2;
    localparam logic [3:0] MODE_READY   = 4'd3;
    localparam logic [3:0] MODE_DSETUP  = 4'd4;
    localparam logic [3:0] MODE_DRIVE   = 4'd5;
    localparam logic [3:0] MODE_LPRESS  = 4'd6;
    localparam logic [3:0] MODE_IDLE    = 4'd7;
    localparam logic [3:0] MODE_BTSETUP = 4'd8;
    localparam logic [3:0] MODE_BT      = 4'd9;

    // beep request codes
    localparam logic [1:0] BEEP_NONE   = 2'd0;
    localparam logic [1:0] BEEP_IDLE   = 2'd1;
    localparam logic [1:0] BEEP_BT     = 2'd2;
    localparam logic [1:0] BEEP_RESUME = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_IDX_CHAIR_POWER = 2'd0;
    localparam logic [1:0] CFG_IDX_NEUTRAL     = 2'd1;
    localparam logic [1:0] CFG_IDX_LONG_PRESS  = 2'd2;

    localparam int PAD_COUNT = 4;

    // reset values of the registers
    localparam logic [9:0]  NEUTRAL_HOLD_RESET = 10'd50;
    localparam logic [11:0] LONG_PRESS_RESET   = 12'd300;

    // demand levels
    localparam logic signed [7:0] DEMAND_POS  = 8'sd100;
    localparam logic signed [7:0] DEMAND_NEG  = -8'sd100;
    localparam logic signed [7:0] DEMAND_ZERO = 8'sd0;

    // field positions on the stream buses
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    localparam int TUSER_DRIVE_VALID  = 0;
    localparam int TUSER_MIRROR_VALID = 1;

endpackage

// ===== hw/rtl/head_array_drive_mode_controller_core.sv =====
`timescale 1ns / 1ps

// head array drive mode controller: each input beat is one control tick carrying the user
// switch and the four head pads; the block steps a ten-state mode machine (startup delay,
// neutral test, drive setup, driving, long-press detection, drive idle, bluetooth setup and
// mirroring) and returns exactly one result beat per input beat with the new mode, the
// drive demand, LED level, beep request, mirrored pads and beeping permission. a tick goes
// through an input register and one stage of logic into the result register, so one beat
// is taken every clock unless a result waiting on m_tready stalls the stage; the only
// loop is the state update, closed within that single stage. while a result waits on
// m_tready the input register still holds one further beat. configuration is written
// through the cfg channel, which is always ready, and is meant to change only while idle.
module head_array_drive_mode_controller_core
    import hadm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    // input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [0] switch, [1] pad_left, [2] pad_right, [3] pad_center, [4] pad_back
    input  logic [S_TDATA_W-1:0] s_tdata,

    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [3:0] mode, [11:4] speed_percent, [19:12] direction_percent, [20] power_led,
    // [22:21] beep_request, [26:23] mirror_pads, [27] beeping_allowed
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] drive_valid, [1] mirror_valid
    output logic [M_TUSER_W-1:0] m_tuser,

    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [11:0]          cfg_data
);

    // configuration registers
    logic        chair_power_reg;
    logic [9:0]  neutral_hold_reg;
    logic [11:0] long_press_reg;

    // input register
    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;

    // mode machine state
    logic [3:0]  mode_reg,     mode_next;
    logic [9:0]  neutral_reg,  neutral_next;
    logic [11:0] press_reg,    press_next;
    logic        led_reg,      led_next;

    // result register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_user_reg;

    // per-tick results
    logic                 drive_valid;
    logic                 mirror_valid;
    logic signed [7:0]    speed;
    logic signed [7:0]    dir;
    logic [1:0]           beep;
    logic [PAD_COUNT-1:0] mirror;
    logic                 beep_allowed;

    logic                 sw;
    logic [PAD_COUNT-1:0] pads;

    // neutral hold countdown with clamp to the hold setting
    logic [9:0] hold_clamped;
    logic       hold_done;
    logic [9:0] hold_left;

    logic [11:0] press_dec;

    logic advance;
    logic fire;

    // the stage moves when the result register is free or being emptied
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign sw   = in_data_reg[0];
    assign pads = in_data_reg[PAD_COUNT:1];

    assign hold_clamped = (neutral_reg > neutral_hold_reg) ? neutral_hold_reg : neutral_reg;
    assign hold_done    = (hold_clamped <= 10'd1);
    assign hold_left    = hold_done ? 10'd0 : (hold_clamped - 10'd1);

    assign press_dec = (press_reg != 12'd0) ? (press_reg - 12'd1) : press_reg;

    always_comb begin
        mode_next    = mode_reg;
        neutral_next = neutral_reg;
        press_next   = press_reg;
        led_next     = led_reg;
        drive_valid  = 1'b0;
        mirror_valid = 1'b0;
        speed        = DEMAND_ZERO;
        dir          = DEMAND_ZERO;
        beep         = BEEP_NONE;
        mirror       = '0;

        case (mode_reg)
            MODE_NSETUP: begin
                neutral_next = neutral_hold_reg;
                mode_next    = MODE_NWAIT;
            end
            MODE_NWAIT: begin
                if (pads == '0) begin
                    neutral_next = hold_left;
                    if (hold_done) begin
                        mode_next = MODE_READY;
                    end
                end else begin
                    neutral_next = neutral_hold_reg;
                end
            end
            MODE_READY: begin
                mode_next = MODE_DSETUP;
            end
            MODE_DSETUP: begin
                if (!sw) begin
                    mode_next = MODE_DRIVE;
                end
            end
            MODE_DRIVE: begin
                drive_valid = 1'b1;
                // priority left, right, center, back; a held switch zeroes the demand
                if (sw) begin
                    led_next   = 1'b0;
                    beep       = BEEP_IDLE;
                    press_next = long_press_reg;
                    mode_next  = MODE_LPRESS;
                end else if (pads[0]) begin
                    dir = DEMAND_NEG;
                end else if (pads[1]) begin
                    dir = DEMAND_POS;
                end else if (pads[2]) begin
                    speed = DEMAND_POS;
                end else if (pads[3]) begin
                    speed = DEMAND_NEG;
                end
            end
            MODE_LPRESS: begin
                if (sw) begin
                    press_next = press_dec;
                    if (press_dec == 12'd0) begin
                        beep      = BEEP_BT;
                        mode_next = MODE_BTSETUP;
                    end
                end else begin
                    led_next  = 1'b0;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_IDLE: begin
                if (sw) begin
                    beep      = BEEP_RESUME;
                    led_next  = 1'b1;
                    mode_next = chair_power_reg ? MODE_DSETUP : MODE_NSETUP;
                end
            end
            MODE_BTSETUP: begin
                if (!sw) begin
                    mode_next = MODE_BT;
                end
            end
            MODE_BT: begin
                if (sw) begin
                    neutral_next = neutral_hold_reg;
                    mode_next    = MODE_NSETUP;
                end
                mirror_valid = 1'b1;
                mirror       = pads;
            end
            default: begin
                // startup delay, also taken for codes that never arise
                neutral_next = hold_left;
                mode_next    = MODE_STARTUP;
                if (hold_done) begin
                    neutral_next = neutral_hold_reg;
                    if (chair_power_reg) begin
                        led_next  = 1'b1;
                        mode_next = MODE_NWAIT;
                    end else begin
                        led_next  = 1'b0;
                        mode_next = MODE_IDLE;
                    end
                end
            end
        endcase

        beep_allowed = (mode_next != MODE_IDLE);
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chair_power_reg  <= 1'b0;
            neutral_hold_reg <= NEUTRAL_HOLD_RESET;
            long_press_reg   <= LONG_PRESS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_CHAIR_POWER: chair_power_reg  <= cfg_data[0];
                CFG_IDX_NEUTRAL:     neutral_hold_reg <= cfg_data[9:0];
                CFG_IDX_LONG_PRESS:  long_press_reg   <= cfg_data;
                default: begin
                    // unknown index is dropped
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
        end
    end

    // mode machine state, stepped once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_STARTUP;
            neutral_reg <= NEUTRAL_HOLD_RESET;
            press_reg   <= '0;
            led_reg     <= 1'b0;
        end else if (fire) begin
            mode_reg    <= mode_next;
            neutral_reg <= neutral_next;
            press_reg   <= press_next;
            led_reg     <= led_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {4'b0000, beep_allowed, mirror, beep, led_next,
                             dir, speed, mode_next};
            out_user_reg <= {mirror_valid, drive_valid};
        end
    end

endmodule

// ===== hw/rtl/hadm_checker.sv =====
`timescale 1ns / 1ps

module hadm_checker
    import hadm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    logic [3:0] mode_f;
    logic [1:0] beep_f;

    assign mode_f = m_tdata[3:0];
    assign beep_f = m_tdata[22:21];

    // drive and mirror ticks are never the same tick
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[TUSER_DRIVE_VALID] && m_tuser[TUSER_MIRROR_VALID]))
        else $error("drive and mirror flagged together");

    // a drive tick leaves the machine driving or in long-press detection
    a_drive_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[TUSER_DRIVE_VALID] |->
            (mode_f == MODE_DRIVE || mode_f == MODE_LPRESS))
        else $error("drive tick in wrong mode");

    // no demand outside drive ticks
    a_no_demand: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[TUSER_DRIVE_VALID] |-> m_tdata[19:4] == 16'd0)
        else $error("demand without drive tick");

    // beeping permission follows the reported mode
    a_beep_allowed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[27] == (mode_f != MODE_IDLE))
        else $error("beeping permission disagrees with mode");

    // the bluetooth beep comes with entry to bluetooth setup
    a_bt_beep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && beep_f == BEEP_BT |-> mode_f == MODE_BTSETUP)
        else $error("bluetooth beep without bluetooth setup");

endmodule

bind head_array_drive_mode_controller_core hadm_checker u_hadm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/head_array_drive_mode_controller_core_tb.sv =====
`timescale 1ns / 1ps

module head_array_drive_mode_controller_core_tb;
    import hadm_pkg::*;

    // register index that the block has to ignore
    localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;

    // idling patterns: sender/receiver 37/62, then 62/37, then none
    localparam int IDLE_SRC_LIGHT = 0;
    localparam int IDLE_SRC_HEAVY = 1;
    localparam int IDLE_NONE      = 2;

    // one expected result beat
    typedef struct packed {
        logic [3:0]        mode;
        logic              drive_valid;
        logic signed [7:0] speed;
        logic signed [7:0] direction;
        logic              led;
        logic [1:0]        beep;
        logic              mirror_valid;
        logic [3:0]        mirror;
        logic              beep_ok;
    } tick_report_t;

    typedef struct {
        logic        chair;
        logic [11:0] hold;
        logic [11:0] press;
        int          count;
        int          idling;
        bit          drain_midway;
    } phase_t;

    // mode machine tracker and store of the results still due
    class drive_mode_scoreboard;
        logic         chair_on;
        logic [9:0]   hold_ticks;
        logic [11:0]  press_ticks;
        logic [3:0]   mode;
        logic [9:0]   neutral_cnt;
        logic [11:0]  press_cnt;
        logic         led;
        tick_report_t reports_due[$];
        int           errors;

        function new();
            chair_on    = 1'b0;
            hold_ticks  = NEUTRAL_HOLD_RESET;
            press_ticks = LONG_PRESS_RESET;
            mode        = MODE_STARTUP;
            neutral_cnt = NEUTRAL_HOLD_RESET;
            press_cnt   = '0;
            led         = 1'b0;
            errors      = 0;
        endfunction

        function void configure(logic [1:0] idx, logic [11:0] data);
            case (idx)
                CFG_IDX_CHAIR_POWER: chair_on = data[0];
                CFG_IDX_NEUTRAL:     hold_ticks = data[9:0];
                CFG_IDX_LONG_PRESS:  press_ticks = data;
                default: ;
            endcase
        endfunction

        // clamp to the hold, then count down; true once the hold has run out
        function bit hold_elapsed();
            logic [9:0] c;
            c = (neutral_cnt > hold_ticks) ? hold_ticks : neutral_cnt;
            if (c <= 10'd1) begin
                neutral_cnt = '0;
                return 1'b1;
            end
            neutral_cnt = c - 10'd1;
            return 1'b0;
        endfunction

        // bits: [0] switch, [1] left, [2] right, [3] center, [4] back
        function void take_tick(logic [4:0] bits);
            tick_report_t r;
            logic         sw;
            logic [3:0]   pads;
            sw   = bits[0];
            pads = bits[4:1];
            r    = '0;
            case (mode)
                MODE_NSETUP: begin
                    neutral_cnt = hold_ticks;
                    mode = MODE_NWAIT;
                end
                MODE_NWAIT: begin
                    if (pads == 4'd0) begin
                        if (hold_elapsed())
                            mode = MODE_READY;
                    end else begin
                        neutral_cnt = hold_ticks;
                    end
                end
                MODE_READY: mode = MODE_DSETUP;
                MODE_DSETUP: begin
                    if (!sw)
                        mode = MODE_DRIVE;
                end
                MODE_DRIVE: begin
                    r.drive_valid = 1'b1;
                    if (pads[0])      r.direction = DEMAND_NEG;
                    else if (pads[1]) r.direction = DEMAND_POS;
                    else if (pads[2]) r.speed = DEMAND_POS;
                    else if (pads[3]) r.speed = DEMAND_NEG;
                    if (sw) begin
                        r.speed     = DEMAND_ZERO;
                        r.direction = DEMAND_ZERO;
                        led         = 1'b0;
                        r.beep      = BEEP_IDLE;
                        press_cnt   = press_ticks;
                        mode        = MODE_LPRESS;
                    end
                end
                MODE_LPRESS: begin
                    if (sw) begin
                        if (press_cnt != 12'd0)
                            press_cnt = press_cnt - 12'd1;
                        if (press_cnt == 12'd0) begin
                            r.beep = BEEP_BT;
                            mode = MODE_BTSETUP;
                        end
                    end else begin
                        led  = 1'b0;
                        mode = MODE_IDLE;
                    end
                end
                MODE_IDLE: begin
                    if (sw) begin
                        r.beep = BEEP_RESUME;
                        led    = 1'b1;
                        mode   = chair_on ? MODE_DSETUP : MODE_NSETUP;
                    end
                end
                MODE_BTSETUP: begin
                    if (!sw)
                        mode = MODE_BT;
                end
                MODE_BT: begin
                    if (sw) begin
                        neutral_cnt = hold_ticks;
                        mode = MODE_NSETUP;
                    end
                    r.mirror_valid = 1'b1;
                    r.mirror = pads;
                end
                default: begin
                    if (hold_elapsed()) begin
                        neutral_cnt = hold_ticks;
                        led  = chair_on;
                        mode = chair_on ? MODE_NWAIT : MODE_IDLE;
                    end else begin
                        mode = MODE_STARTUP;
                    end
                end
            endcase
            r.mode    = mode;
            r.led     = led;
            r.beep_ok = (mode != MODE_IDLE);
            reports_due.push_back(r);
        endfunction

        function void compare_field(string what, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            tick_report_t want;
            if (reports_due.size() == 0) begin
                $display("%0t: result beat with nothing expected, expected none, actual %h/%b",
                         $time, tdata, tuser);
                errors++;
                return;
            end
            want = reports_due.pop_front();
            compare_field("mode", want.mode, tdata[3:0]);
            compare_field("speed_percent", want.speed, $signed(tdata[11:4]));
            compare_field("direction_percent", want.direction, $signed(tdata[19:12]));
            compare_field("power_led", want.led, tdata[20]);
            compare_field("beep_request", want.beep, tdata[22:21]);
            compare_field("mirror_pads", want.mirror, tdata[26:23]);
            compare_field("beeping_allowed", want.beep_ok, tdata[27]);
            compare_field("drive_valid", want.drive_valid, tuser[TUSER_DRIVE_VALID]);
            compare_field("mirror_valid", want.mirror_valid, tuser[TUSER_MIRROR_VALID]);
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [11:0]          cfg_data = '0;

    drive_mode_scoreboard sb;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int cycle_count   = 0;

    head_array_drive_mode_controller_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check each accepted beat, then stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_report(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic set_idling(input int pattern);
        case (pattern)
            IDLE_SRC_LIGHT: begin
                src_idle_pct  = 37;
                sink_idle_pct = 62;
            end
            IDLE_SRC_HEAVY: begin
                src_idle_pct  = 62;
                sink_idle_pct = 37;
            end
            default: begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
        endcase
    endtask

    // all three registers plus one beat to an index that does not exist
    task automatic write_settings(input logic chair, input logic [11:0] hold,
                                  input logic [11:0] press);
        logic [1:0]  idx [4];
        logic [11:0] val [4];
        idx = '{CFG_IDX_CHAIR_POWER, CFG_IDX_NEUTRAL, CFG_IDX_LONG_PRESS, CFG_IDX_UNUSED};
        val = '{{11'd0, chair}, hold, press, 12'($urandom_range(4095))};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.configure(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input logic [4:0] bits);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-5){1'b0}}, bits};
        do @(posedge aclk); while (!s_tready);
        sb.take_tick(bits);
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.reports_due.size() != 0);
    endtask

    // bias the next tick towards whatever moves the current mode along
    function automatic logic [4:0] pick_tick(logic [3:0] cur);
        logic       sw;
        logic [3:0] pads;
        sw   = 1'($urandom_range(1));
        pads = 4'($urandom_range(15));
        // about one tick in ten stays pure noise
        if ($urandom_range(99) >= 10) begin
            case (cur)
                MODE_NWAIT:   pads = ($urandom_range(9) == 0) ? pads : 4'd0;
                MODE_DSETUP:  sw = ($urandom_range(99) < 30);
                MODE_DRIVE:   sw = ($urandom_range(99) < 12);
                MODE_LPRESS:  sw = ($urandom_range(99) < 85);
                MODE_IDLE:    sw = ($urandom_range(99) < 40);
                MODE_BTSETUP: sw = ($urandom_range(99) < 40);
                MODE_BT:      sw = ($urandom_range(99) < 15);
                default: ;
            endcase
        end
        return {pads, sw};
    endfunction

    initial begin
        // bits {back, center, right, left, switch}: startup clamp, neutral wait broken by a
        // pad, switch held in drive setup, every pad priority, switch held while driving,
        // long press to bluetooth, mirroring, resume via neutral test, short press to idle
        // and resume straight to drive setup
        logic [4:0] directed [28] = '{
            5'b00000, 5'b00000, 5'b00010, 5'b00000, 5'b00000, 5'b00000, 5'b00001,
            5'b00000, 5'b11110, 5'b11100, 5'b11000, 5'b10000, 5'b00000, 5'b01001,
            5'b00001, 5'b00001, 5'b00000, 5'b10100, 5'b01010, 5'b11111, 5'b00000,
            5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00001, 5'b00000, 5'b00001
        };
        // short settings, zero hold and zero long press, the extremes with spare upper bits, short again
        phase_t phases [5] = '{
            '{1'b0, 12'd3,     12'd3,    150, IDLE_SRC_LIGHT, 1'b1},
            '{1'b1, 12'd0,     12'd0,    120, IDLE_SRC_HEAVY, 1'b0},
            '{1'b0, 12'hFFF,   12'd4095, 120, IDLE_SRC_HEAVY, 1'b0},
            '{1'b1, 12'd5,     12'd7,    150, IDLE_NONE,      1'b0},
            '{1'b0, 12'd1,     12'd1,    150, IDLE_NONE,      1'b0}
        };

        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short hold and press so the directed run walks every mode
        write_settings(1'b1, 12'd2, 12'd2);
        set_idling(IDLE_SRC_LIGHT);
        foreach (directed[i])
            send_tick(directed[i]);
        drain_results();

        foreach (phases[p]) begin
            write_settings(phases[p].chair, phases[p].hold, phases[p].press);
            set_idling(phases[p].idling);
            for (int n = 0; n < phases[p].count; n++) begin
                send_tick(pick_tick(sb.mode));
                // hold off the sender once until the pipeline is empty
                if (phases[p].drain_midway && n == phases[p].count / 2)
                    drain_results();
            end
            drain_results();
        end

        // wait on to catch any stray result beat
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.reports_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/hadm_pkg.sv
hw/rtl/head_array_drive_mode_controller_core.sv
hw/rtl/hadm_checker.sv
test/head_array_drive_mode_controller_core_tb.sv
